### rtl/idp_pkg.sv
// ----------------------------------------------------------------------------
// idp_pkg
// Shared types and constants of the ISO 8601 date-time parser: character
// classes, token and result words, parser phases and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package idp_pkg;

  // Character codes the parser looks for
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_Z     = 8'h5A;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_DOT   = 8'h2E;

  // Precision codes
  localparam logic [3:0] PREC_NONE   = 4'd0;
  localparam logic [3:0] PREC_YEAR   = 4'd1;
  localparam logic [3:0] PREC_MONTH  = 4'd2;
  localparam logic [3:0] PREC_DAY    = 4'd3;
  localparam logic [3:0] PREC_HOUR   = 4'd4;
  localparam logic [3:0] PREC_MINUTE = 4'd5;
  localparam logic [3:0] PREC_SECOND = 4'd6;
  localparam logic [3:0] PREC_FRAC   = 4'd7;
  localparam logic [3:0] PREC_ZHOUR  = 4'd8;
  localparam logic [3:0] PREC_ZMIN   = 4'd9;

  // Zone kinds
  localparam logic [1:0] ZONE_NONE  = 2'd0;
  localparam logic [1:0] ZONE_Z     = 2'd1;
  localparam logic [1:0] ZONE_PLUS  = 2'd2;
  localparam logic [1:0] ZONE_MINUS = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SEP   = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_T     = 3'd1,
    CLS_MINUS = 3'd2,
    CLS_PLUS  = 3'd3,
    CLS_COLON = 3'd4,
    CLS_Z     = 3'd5,
    CLS_DOT   = 3'd6,
    CLS_OTHER = 3'd7
  } cls_e;

  // Classified character as passed from front to back
  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
    logic       last;
    logic       time_only;
  } tok_t;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [15:0] fraction;
    logic [3:0]  precision;
    logic [1:0]  zone_kind;
    logic [6:0]  zone_hour;
    logic [6:0]  zone_minute;
    logic [1:0]  status;
  } res_t;

  typedef enum logic [27:0] {
    PH_Y0    = 28'h0000001,
    PH_Y1    = 28'h0000002,
    PH_Y2    = 28'h0000004,
    PH_Y3    = 28'h0000008,
    PH_AY    = 28'h0000010,
    PH_MO0   = 28'h0000020,
    PH_MO1   = 28'h0000040,
    PH_AMO   = 28'h0000080,
    PH_D0    = 28'h0000100,
    PH_D1    = 28'h0000200,
    PH_AD    = 28'h0000400,
    PH_H0    = 28'h0000800,
    PH_H1    = 28'h0001000,
    PH_AH    = 28'h0002000,
    PH_MI0   = 28'h0004000,
    PH_MI1   = 28'h0008000,
    PH_AMI   = 28'h0010000,
    PH_S0    = 28'h0020000,
    PH_S1    = 28'h0040000,
    PH_AS    = 28'h0080000,
    PH_FR    = 28'h0100000,
    PH_ZH0   = 28'h0200000,
    PH_ZH1   = 28'h0400000,
    PH_AZH   = 28'h0800000,
    PH_ZM0   = 28'h1000000,
    PH_ZM1   = 28'h2000000,
    PH_SINK  = 28'h4000000,
    PH_START = 28'h8000000
  } phase_e;

  // Two-digit field: v * 10 + d, kept to 7 bits
  function automatic logic [6:0] acc7(logic [6:0] v, logic [3:0] d);
    logic [9:0] t;
    t = {v, 3'b000} + {2'b00, v, 1'b0} + {6'b000000, d};
    return t[6:0];
  endfunction

  // Year field: v * 10 + d, kept to 14 bits
  function automatic logic [13:0] acc14(logic [13:0] v, logic [3:0] d);
    logic [16:0] t;
    t = {v, 3'b000} + {2'b00, v, 1'b0} + {13'b0, d};
    return t[13:0];
  endfunction

endpackage

`default_nettype wire

### rtl/idp_fifo.sv
// ----------------------------------------------------------------------------
// idp_fifo
// Two-entry queue of fixed-width words with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      rdata_o,
  output logic                  empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and word count
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/idp_front.sv
// ----------------------------------------------------------------------------
// idp_front
// Input side: classifies each character into a token and queues it for the
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire logic [7:0]    char_code_i,
  input  wire logic          last_i,
  input  wire logic          time_only_i,
  input  wire logic          tok_pop_i,
  output logic               tok_empty_o,
  output idp_pkg::tok_t      tok_o
);

  import idp_pkg::*;

  tok_t             tok_in;
  logic [$bits(tok_t)-1:0] tok_bits;

  // Classify the character
  always_comb begin
    tok_in.digit     = char_code_i[3:0];
    tok_in.last      = last_i;
    tok_in.time_only = time_only_i;
    priority if (char_code_i >= CHR_0 && char_code_i <= CHR_9) begin
      tok_in.cls = CLS_DIGIT;
    end else if (char_code_i == CHR_T) begin
      tok_in.cls = CLS_T;
    end else if (char_code_i == CHR_MINUS) begin
      tok_in.cls = CLS_MINUS;
    end else if (char_code_i == CHR_PLUS) begin
      tok_in.cls = CLS_PLUS;
    end else if (char_code_i == CHR_COLON) begin
      tok_in.cls = CLS_COLON;
    end else if (char_code_i == CHR_Z) begin
      tok_in.cls = CLS_Z;
    end else if (char_code_i == CHR_DOT) begin
      tok_in.cls = CLS_DOT;
    end else begin
      tok_in.cls = CLS_OTHER;
    end
  end

  // Hold tokens until the parser takes them
  idp_fifo #(
    .Width ($bits(tok_t))
  ) u_tok_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (tok_in),
    .full_o  (full_o),
    .pop_i   (tok_pop_i),
    .rdata_o (tok_bits),
    .empty_o (tok_empty_o)
  );

  assign tok_o = tok_t'(tok_bits);

endmodule

`default_nettype wire

### rtl/idp_back.sv
// ----------------------------------------------------------------------------
// idp_back
// Parser side: steps the phase machine once per token, accumulates the
// fields and queues one result word per string.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_back #(
  parameter int unsigned FRACTION_WIDTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          tok_empty_i,
  input  wire idp_pkg::tok_t tok_i,
  output logic               tok_pop_o,
  input  wire logic          res_pop_i,
  output logic               res_empty_o,
  output idp_pkg::res_t      res_o
);

  import idp_pkg::*;

  phase_e                    phase_q, phase_d, ph;
  logic [13:0]               year_q, year_d;
  logic [6:0]                month_q, month_d;
  logic [6:0]                day_q, day_d;
  logic [6:0]                hour_q, hour_d;
  logic [6:0]                minute_q, minute_d;
  logic [6:0]                second_q, second_d;
  logic [FRACTION_WIDTH-1:0] frac_q, frac_d;
  logic [3:0]                prec_q, prec_d;
  logic [1:0]                zkind_q, zkind_d;
  logic [6:0]                zhour_q, zhour_d;
  logic [6:0]                zmin_q, zmin_d;
  logic [1:0]                status_q, status_d;

  logic                      fire, res_full, res_push;
  logic                      is_dig, is_zone, short_end;
  logic                      fail_en;
  logic [1:0]                fail_code;
  logic [FRACTION_WIDTH+3:0] frac_t;
  logic [FRACTION_WIDTH+15:0] frac_ext;
  res_t                      res_d;
  logic [$bits(res_t)-1:0]   res_bits;

  // Take a token unless it ends a string and the result queue is full
  assign fire      = !tok_empty_i && (!tok_i.last || !res_full);
  assign tok_pop_o = fire;
  assign res_push  = fire && tok_i.last;

  assign is_dig  = (tok_i.cls == CLS_DIGIT);
  assign is_zone = (tok_i.cls == CLS_Z) || (tok_i.cls == CLS_PLUS) ||
                   (tok_i.cls == CLS_MINUS);
  assign frac_t  = {frac_q, 3'b000} + {2'b00, frac_q, 1'b0} +
                   (FRACTION_WIDTH+4)'(tok_i.digit);

  // Step the phase machine
  always_comb begin
    year_d    = year_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    frac_d    = frac_q;
    prec_d    = prec_q;
    zkind_d   = zkind_q;
    zhour_d   = zhour_q;
    zmin_d    = zmin_q;
    status_d  = status_q;
    fail_en   = 1'b0;
    fail_code = ST_OK;
    short_end = 1'b0;
    frac_ext  = '0;
    res_d     = '0;

    ph = phase_q;
    if (ph == PH_START) begin
      ph = tok_i.time_only ? PH_H0 : PH_Y0;
    end

    unique case (ph)
      PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          year_d = acc14(year_q, tok_i.digit);
          if (ph == PH_Y3) begin
            prec_d = PREC_YEAR; ph = PH_AY;
          end else begin
            ph = phase_e'({ph[26:0], 1'b0});
          end
        end
      end
      PH_AY, PH_AMO: begin
        if (tok_i.cls == CLS_T) begin
          ph = PH_H0;
        end else if (tok_i.cls == CLS_MINUS) begin
          ph = (ph == PH_AY) ? PH_MO0 : PH_D0;
        end else begin
          fail_en = 1'b1; fail_code = ST_SEP;
        end
      end
      PH_MO0, PH_MO1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          month_d = acc7(month_q, tok_i.digit);
          if (ph == PH_MO1) begin
            prec_d = PREC_MONTH; ph = PH_AMO;
          end else begin
            ph = PH_MO1;
          end
        end
      end
      PH_D0, PH_D1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          day_d = acc7(day_q, tok_i.digit);
          if (ph == PH_D1) begin
            prec_d = PREC_DAY; ph = PH_AD;
          end else begin
            ph = PH_D1;
          end
        end
      end
      PH_AD: begin
        ph = (tok_i.cls == CLS_T) ? PH_H0 : PH_SINK;
      end
      PH_H0, PH_H1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          hour_d = acc7(hour_q, tok_i.digit);
          if (ph == PH_H1) begin
            prec_d = PREC_HOUR; ph = PH_AH;
          end else begin
            ph = PH_H1;
          end
        end
      end
      PH_AH, PH_AMI: begin
        if (tok_i.cls == CLS_Z) begin
          zkind_d = ZONE_Z; ph = PH_SINK;
        end else if (is_zone) begin
          zkind_d = (tok_i.cls == CLS_PLUS) ? ZONE_PLUS : ZONE_MINUS;
          ph = PH_ZH0;
        end else if (tok_i.cls == CLS_COLON) begin
          ph = (ph == PH_AH) ? PH_MI0 : PH_S0;
        end else begin
          fail_en = 1'b1; fail_code = ST_SEP;
        end
      end
      PH_MI0, PH_MI1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          minute_d = acc7(minute_q, tok_i.digit);
          if (ph == PH_MI1) begin
            prec_d = PREC_MINUTE; ph = PH_AMI;
          end else begin
            ph = PH_MI1;
          end
        end
      end
      PH_S0, PH_S1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          second_d = acc7(second_q, tok_i.digit);
          if (ph == PH_S1) begin
            prec_d = PREC_SECOND; ph = PH_AS;
          end else begin
            ph = PH_S1;
          end
        end
      end
      PH_AS: begin
        if (tok_i.cls == CLS_Z) begin
          zkind_d = ZONE_Z; ph = PH_SINK;
        end else if (is_zone) begin
          zkind_d = (tok_i.cls == CLS_PLUS) ? ZONE_PLUS : ZONE_MINUS;
          ph = PH_ZH0;
        end else if (tok_i.cls == CLS_DOT) begin
          prec_d = PREC_FRAC; ph = PH_FR;
        end else begin
          ph = PH_SINK;
        end
      end
      PH_FR: begin
        if (tok_i.cls == CLS_Z) begin
          zkind_d = ZONE_Z; ph = PH_SINK;
        end else if (is_zone) begin
          zkind_d = (tok_i.cls == CLS_PLUS) ? ZONE_PLUS : ZONE_MINUS;
          ph = PH_ZH0;
        end else if (is_dig) begin
          frac_d = frac_t[FRACTION_WIDTH-1:0];
        end else begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end
      end
      PH_ZH0, PH_ZH1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          zhour_d = acc7(zhour_q, tok_i.digit);
          if (ph == PH_ZH1) begin
            prec_d = PREC_ZHOUR; ph = PH_AZH;
          end else begin
            ph = PH_ZH1;
          end
        end
      end
      PH_AZH: begin
        if (tok_i.cls == CLS_COLON) begin
          ph = PH_ZM0;
        end else begin
          fail_en = 1'b1; fail_code = ST_SEP;
        end
      end
      PH_ZM0, PH_ZM1: begin
        if (!is_dig) begin
          fail_en = 1'b1; fail_code = ST_DIGIT;
        end else begin
          zmin_d = acc7(zmin_q, tok_i.digit);
          if (ph == PH_ZM1) begin
            prec_d = PREC_ZMIN; ph = PH_SINK;
          end else begin
            ph = PH_ZM1;
          end
        end
      end
      default: begin
        ph = PH_SINK;
      end
    endcase

    // Stop on error; the first error keeps its code
    if (fail_en) begin
      if (status_d == ST_OK) begin
        status_d = fail_code;
      end
      ph = PH_SINK;
    end

    // Flag a string that ends inside a group or after a separator
    short_end = !(ph == PH_AY || ph == PH_AMO || ph == PH_AD || ph == PH_AH ||
                  ph == PH_AMI || ph == PH_AS || ph == PH_FR || ph == PH_SINK ||
                  ph == PH_START);
    if (tok_i.last && short_end && status_d == ST_OK) begin
      status_d = ST_SHORT;
    end

    // Assemble the result word
    frac_ext          = {16'h0000, frac_d};
    res_d.year        = year_d;
    res_d.month       = month_d;
    res_d.day         = day_d;
    res_d.hour        = hour_d;
    res_d.minute      = minute_d;
    res_d.second      = second_d;
    res_d.fraction    = frac_ext[15:0];
    res_d.precision   = prec_d;
    res_d.zone_kind   = zkind_d;
    res_d.zone_hour   = zhour_d;
    res_d.zone_minute = zmin_d;
    res_d.status      = status_d;

    phase_d = ph;

    // Drop all state once the string is done
    if (tok_i.last) begin
      phase_d  = PH_START;
      year_d   = '0;
      month_d  = '0;
      day_d    = '0;
      hour_d   = '0;
      minute_d = '0;
      second_d = '0;
      frac_d   = '0;
      prec_d   = PREC_NONE;
      zkind_d  = ZONE_NONE;
      zhour_d  = '0;
      zmin_d   = '0;
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_START;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
      prec_q   <= PREC_NONE;
      zkind_q  <= ZONE_NONE;
      zhour_q  <= '0;
      zmin_q   <= '0;
      status_q <= ST_OK;
    end else if (fire) begin
      phase_q  <= phase_d;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
      hour_q   <= hour_d;
      minute_q <= minute_d;
      second_q <= second_d;
      frac_q   <= frac_d;
      prec_q   <= prec_d;
      zkind_q  <= zkind_d;
      zhour_q  <= zhour_d;
      zmin_q   <= zmin_d;
      status_q <= status_d;
    end
  end

  // Hold finished results until they are taken
  idp_fifo #(
    .Width ($bits(res_t))
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_d),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .rdata_o (res_bits),
    .empty_o (res_empty_o)
  );

  assign res_o = res_t'(res_bits);

endmodule

`default_nettype wire

### rtl/iso8601_datetime_parser.sv
// ----------------------------------------------------------------------------
// iso8601_datetime_parser
// Streaming parser for ISO 8601 date-times and times, one character a word.
// ----------------------------------------------------------------------------
// Characters go in on the push side, one per cycle while full is low; the
// word marked last closes the string and yields one result word, which is
// written to the pop side when the parser takes its token from the token
// queue and can then be popped. The front classifies each character and
// queues up to two tokens; the back steps the phase machine once per token,
// so the parser register sets the rate of one character a cycle. Up to two
// results can wait on the pop side before the parser stalls on a closing
// character. The fraction accumulator is FRACTION_WIDTH bits wide and
// reported in its low 16 bits, zero-extended if narrower.
// ----------------------------------------------------------------------------
`default_nettype none

module iso8601_datetime_parser #(
  parameter int unsigned FRACTION_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        last_i,
  input  wire logic        time_only_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [13:0]      year_o,
  output logic [6:0]       month_o,
  output logic [6:0]       day_o,
  output logic [6:0]       hour_o,
  output logic [6:0]       minute_o,
  output logic [6:0]       second_o,
  output logic [15:0]      fraction_o,
  output logic [3:0]       precision_o,
  output logic [1:0]       zone_kind_o,
  output logic [6:0]       zone_hour_o,
  output logic [6:0]       zone_minute_o,
  output logic [1:0]       status_o
);

  import idp_pkg::*;

  tok_t tok;
  logic tok_empty, tok_pop;
  res_t res;

  // Classify and queue characters
  idp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .time_only_i (time_only_i),
    .tok_pop_i   (tok_pop),
    .tok_empty_o (tok_empty),
    .tok_o       (tok)
  );

  // Parse tokens and queue results
  idp_back #(
    .FRACTION_WIDTH (FRACTION_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_empty_i (tok_empty),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign year_o        = res.year;
  assign month_o       = res.month;
  assign day_o         = res.day;
  assign hour_o        = res.hour;
  assign minute_o      = res.minute;
  assign second_o      = res.second;
  assign fraction_o    = res.fraction;
  assign precision_o   = res.precision;
  assign zone_kind_o   = res.zone_kind;
  assign zone_hour_o   = res.zone_hour;
  assign zone_minute_o = res.zone_minute;
  assign status_o      = res.status;

endmodule

`default_nettype wire

### rtl/idp_checker.sv
// ----------------------------------------------------------------------------
// idp_checker
// Port-level checks of the date-time parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [13:0] year_o,
  input wire logic [6:0]  month_o,
  input wire logic [6:0]  day_o,
  input wire logic [6:0]  hour_o,
  input wire logic [6:0]  minute_o,
  input wire logic [6:0]  second_o,
  input wire logic [15:0] fraction_o,
  input wire logic [3:0]  precision_o,
  input wire logic [1:0]  zone_kind_o,
  input wire logic [6:0]  zone_hour_o,
  input wire logic [6:0]  zone_minute_o,
  input wire logic [1:0]  status_o
);

  import idp_pkg::*;

  // The result queue comes out of reset empty and the token queue not full
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not empty in reset");

  // A waiting result holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(year_o) && $stable(month_o) &&
                          $stable(day_o) && $stable(hour_o) &&
                          $stable(minute_o) && $stable(second_o) &&
                          $stable(fraction_o) && $stable(precision_o) &&
                          $stable(zone_kind_o) && $stable(zone_hour_o) &&
                          $stable(zone_minute_o) && $stable(status_o)))
    else $error("waiting result changed");

  // Precision never goes past the zone minutes
  a_prec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (precision_o <= PREC_ZMIN))
    else $error("precision out of range");

  // Zone offset only with a signed zone
  a_zone_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (zone_kind_o == ZONE_NONE || zone_kind_o == ZONE_Z)) |->
      (zone_hour_o == 7'd0 && zone_minute_o == 7'd0))
    else $error("zone offset without sign");

  // Zone precision needs a signed zone
  a_zone_prec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (precision_o == PREC_ZHOUR || precision_o == PREC_ZMIN)) |->
      (zone_kind_o == ZONE_PLUS || zone_kind_o == ZONE_MINUS))
    else $error("zone precision without signed zone");

endmodule

bind iso8601_datetime_parser idp_checker u_idp_checker (.*);

`default_nettype wire

### bench/idp_stamp_checker.sv
// ----------------------------------------------------------------------------
// idp_stamp_checker
// Watches both queue sides of the ISO 8601 parser. It predicts the result
// word of every string from the accepted characters and compares each
// popped word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_stamp_checker
  import idp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        last_i,
  input  wire logic        time_only_i,
  input  wire logic        empty_i,
  input  wire logic        pop_i,
  input  wire logic [13:0] year_i,
  input  wire logic [6:0]  month_i,
  input  wire logic [6:0]  day_i,
  input  wire logic [6:0]  hour_i,
  input  wire logic [6:0]  minute_i,
  input  wire logic [6:0]  second_i,
  input  wire logic [15:0] fraction_i,
  input  wire logic [3:0]  precision_i,
  input  wire logic [1:0]  zone_kind_i,
  input  wire logic [6:0]  zone_hour_i,
  input  wire logic [6:0]  zone_minute_i,
  input  wire logic [1:0]  status_i,
  output int unsigned      fail_count_o,
  output int unsigned      stamps_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state of the prediction: phase plus the fields built so far
  phase_e      ph = PH_START;
  res_t        acc = '0;
  res_t        stamps_due[$];
  int unsigned fail_count = 0;

  // Record the first error only and stop parsing
  task automatic halt_parse(logic [1:0] code);
    if (acc.status == ST_OK) acc.status = code;
    ph = PH_SINK;
  endtask

  // Z closes the string; a sign opens the offset hours
  task automatic open_zone(logic [7:0] c);
    if (c == CHR_Z) begin
      acc.zone_kind = ZONE_Z;
      ph = PH_SINK;
    end else begin
      acc.zone_kind = (c == CHR_PLUS) ? ZONE_PLUS : ZONE_MINUS;
      ph = PH_ZH0;
    end
  endtask

  // Advance the prediction by one accepted character
  task automatic parse_char(logic [7:0] c, logic fin, logic tonly);
    logic       dig;
    logic       mark;
    logic [3:0] d;
    dig  = (c >= CHR_0) && (c <= CHR_9);
    mark = (c == CHR_Z) || (c == CHR_PLUS) || (c == CHR_MINUS);
    d    = dig ? 4'(c - CHR_0) : 4'd0;
    if (ph == PH_START) ph = tonly ? PH_H0 : PH_Y0;

    case (ph)
      PH_Y0, PH_Y1, PH_Y2, PH_Y3: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.year = 14'(acc.year * 10 + d);
          case (ph)
            PH_Y0:   ph = PH_Y1;
            PH_Y1:   ph = PH_Y2;
            PH_Y2:   ph = PH_Y3;
            default: begin
              acc.precision = PREC_YEAR;
              ph = PH_AY;
            end
          endcase
        end
      end
      PH_AY, PH_AMO: begin
        if (c == CHR_T) ph = PH_H0;
        else if (c == CHR_MINUS) ph = (ph == PH_AY) ? PH_MO0 : PH_D0;
        else halt_parse(ST_SEP);
      end
      PH_MO0, PH_MO1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.month = 7'(acc.month * 10 + d);
          if (ph == PH_MO0) ph = PH_MO1;
          else begin
            acc.precision = PREC_MONTH;
            ph = PH_AMO;
          end
        end
      end
      PH_D0, PH_D1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.day = 7'(acc.day * 10 + d);
          if (ph == PH_D0) ph = PH_D1;
          else begin
            acc.precision = PREC_DAY;
            ph = PH_AD;
          end
        end
      end
      // anything but T after the day ends the parse quietly
      PH_AD: ph = (c == CHR_T) ? PH_H0 : PH_SINK;
      PH_H0, PH_H1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.hour = 7'(acc.hour * 10 + d);
          if (ph == PH_H0) ph = PH_H1;
          else begin
            acc.precision = PREC_HOUR;
            ph = PH_AH;
          end
        end
      end
      PH_AH, PH_AMI: begin
        if (mark) open_zone(c);
        else if (c == CHR_COLON) ph = (ph == PH_AH) ? PH_MI0 : PH_S0;
        else halt_parse(ST_SEP);
      end
      PH_MI0, PH_MI1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.minute = 7'(acc.minute * 10 + d);
          if (ph == PH_MI0) ph = PH_MI1;
          else begin
            acc.precision = PREC_MINUTE;
            ph = PH_AMI;
          end
        end
      end
      PH_S0, PH_S1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.second = 7'(acc.second * 10 + d);
          if (ph == PH_S0) ph = PH_S1;
          else begin
            acc.precision = PREC_SECOND;
            ph = PH_AS;
          end
        end
      end
      PH_AS: begin
        if (mark) open_zone(c);
        else if (c == CHR_DOT) begin
          acc.precision = PREC_FRAC;
          ph = PH_FR;
        end else ph = PH_SINK;
      end
      // fraction keeps going until a zone mark, a non-digit (an error) or the end
      PH_FR: begin
        if (mark) open_zone(c);
        else if (dig) acc.fraction = 16'(acc.fraction * 10 + d);
        else halt_parse(ST_DIGIT);
      end
      PH_ZH0, PH_ZH1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.zone_hour = 7'(acc.zone_hour * 10 + d);
          if (ph == PH_ZH0) ph = PH_ZH1;
          else begin
            acc.precision = PREC_ZHOUR;
            ph = PH_AZH;
          end
        end
      end
      PH_AZH: begin
        if (c == CHR_COLON) ph = PH_ZM0;
        else halt_parse(ST_SEP);
      end
      PH_ZM0, PH_ZM1: begin
        if (!dig) halt_parse(ST_DIGIT);
        else begin
          acc.zone_minute = 7'(acc.zone_minute * 10 + d);
          if (ph == PH_ZM0) ph = PH_ZM1;
          else begin
            acc.precision = PREC_ZMIN;
            ph = PH_SINK;
          end
        end
      end
      default: ph = PH_SINK;
    endcase

    // Close the string: flag a cut inside a group, queue the word, start over
    if (fin) begin
      if (!(ph inside {PH_AY, PH_AMO, PH_AD, PH_AH, PH_AMI, PH_AS, PH_FR,
                       PH_SINK, PH_START}) && acc.status == ST_OK)
        acc.status = ST_SHORT;
      stamps_due.push_back(acc);
      acc = '0;
      ph  = PH_START;
    end
  endtask

  function automatic string show(res_t r);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d prec %0d zone %0d %0d:%0d st %0d",
                     r.year, r.month, r.day, r.hour, r.minute, r.second,
                     r.fraction, r.precision, r.zone_kind, r.zone_hour,
                     r.zone_minute, r.status);
  endfunction

  // Compare a popped word with the oldest prediction
  task automatic check_stamp();
    res_t got;
    res_t want;
    got = {year_i, month_i, day_i, hour_i, minute_i, second_i, fraction_i,
           precision_i, zone_kind_i, zone_hour_i, zone_minute_i, status_i};
    if (stamps_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%t: result word with none expected: %s", $realtime, show(got));
      return;
    end
    want = stamps_due.pop_front();
    if (got.year !== want.year || got.month !== want.month ||
        got.day !== want.day || got.hour !== want.hour ||
        got.minute !== want.minute || got.second !== want.second ||
        got.fraction !== want.fraction || got.precision !== want.precision ||
        got.zone_kind !== want.zone_kind || got.zone_hour !== want.zone_hour ||
        got.zone_minute !== want.zone_minute || got.status !== want.status) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("%t: result mismatch", $realtime);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endtask

  // Sample both sides at the edge where words are handed over
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph  = PH_START;
      acc = '0;
      stamps_due.delete();
    end else begin
      if (!empty_i && pop_i) check_stamp();
      if (push_i && !full_i) parse_char(char_code_i, last_i, time_only_i);
    end
    fail_count_o <= fail_count;
    stamps_due_o <= stamps_due.size();
  end

endmodule

`default_nettype wire

### bench/iso8601_datetime_parser_tb.sv
// ----------------------------------------------------------------------------
// iso8601_datetime_parser_tb
// Feeds the ISO 8601 parser with directed and random timestamp strings,
// well-formed, cut short, corrupted and pure noise, with random gaps on
// both queue sides. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module iso8601_datetime_parser_tb;
  import idp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] chars_t[$];

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  char_code = '0;
  logic        char_last = 1'b0;
  logic        time_only = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [13:0] year;
  logic [6:0]  month;
  logic [6:0]  day;
  logic [6:0]  hour;
  logic [6:0]  minute;
  logic [6:0]  second;
  logic [15:0] fraction;
  logic [3:0]  precision;
  logic [1:0]  zone_kind;
  logic [6:0]  zone_hour;
  logic [6:0]  zone_minute;
  logic [1:0]  status;

  int unsigned fail_count;
  int unsigned stamps_due;
  int unsigned chars_sent = 0;
  int unsigned push_gap_pct = 0;
  int unsigned pop_gap_pct = 0;
  int unsigned pop_hold = 0;
  chars_t      stamp;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  iso8601_datetime_parser i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code),
    .last_i        (char_last),
    .time_only_i   (time_only),
    .empty         (empty),
    .pop           (pop),
    .year_o        (year),
    .month_o       (month),
    .day_o         (day),
    .hour_o        (hour),
    .minute_o      (minute),
    .second_o      (second),
    .fraction_o    (fraction),
    .precision_o   (precision),
    .zone_kind_o   (zone_kind),
    .zone_hour_o   (zone_hour),
    .zone_minute_o (zone_minute),
    .status_o      (status)
  );

  idp_stamp_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .push_i        (push),
    .full_i        (full),
    .char_code_i   (char_code),
    .last_i        (char_last),
    .time_only_i   (time_only),
    .empty_i       (empty),
    .pop_i         (pop),
    .year_i        (year),
    .month_i       (month),
    .day_i         (day),
    .hour_i        (hour),
    .minute_i      (minute),
    .second_i      (second),
    .fraction_i    (fraction),
    .precision_i   (precision),
    .zone_kind_i   (zone_kind),
    .zone_hour_i   (zone_hour),
    .zone_minute_i (zone_minute),
    .status_i      (status),
    .fail_count_o  (fail_count),
    .stamps_due_o  (stamps_due)
  );

  // Stall the pop side in bursts of random length
  always @(posedge clk) begin
    if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if (pop_gap_pct != 0 && $urandom_range(99) < pop_gap_pct) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(13);
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic chars_t text(string s);
    chars_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 4;
      2:       return 15;
      default: return 45;
    endcase
  endfunction

  // Any byte, a digit, a blank or one of the characters the parser looks for
  function automatic logic [7:0] any_char();
    case ($urandom_range(3))
      0: return 8'($urandom_range(255));
      1: return 8'(CHR_0 + $urandom_range(9));
      default: begin
        case ($urandom_range(6))
          0:       return CHR_T;
          1:       return CHR_Z;
          2:       return CHR_PLUS;
          3:       return CHR_MINUS;
          4:       return CHR_COLON;
          5:       return CHR_DOT;
          default: return 8'h20;
        endcase
      end
    endcase
  endfunction

  function automatic void add_digits(int unsigned n);
    repeat (n) stamp.push_back(8'(CHR_0 + $urandom_range(9)));
  endfunction

  function automatic void add_pair(logic [7:0] sep);
    stamp.push_back(sep);
    add_digits(2);
  endfunction

  // Build a date-time or time with random depth and content, well formed but for an optional random tail
  function automatic logic build_stamp();
    logic        mode;
    logic        with_time;
    int unsigned depth;
    stamp.delete();
    mode = 1'($urandom_range(1));
    with_time = 1'b1;
    if (!mode) begin
      add_digits(4);
      depth = $urandom_range(2);
      repeat (depth) add_pair(CHR_MINUS);
      with_time = $urandom_range(3) != 0;
      if (with_time) stamp.push_back(CHR_T);
      else if (depth == 2 && $urandom_range(2) == 0)
        repeat ($urandom_range(3, 1)) stamp.push_back(any_char());
    end
    if (with_time) begin
      add_digits(2);
      depth = $urandom_range(3);
      if (depth >= 1) add_pair(CHR_COLON);
      if (depth >= 2) add_pair(CHR_COLON);
      if (depth == 3) begin
        stamp.push_back(CHR_DOT);
        add_digits($urandom_range(8));
      end
      case ($urandom_range(4))
        0: stamp.push_back(CHR_Z);
        1, 2: begin
          stamp.push_back($urandom_range(1) ? CHR_PLUS : CHR_MINUS);
          add_digits(2);
          add_pair(CHR_COLON);
        end
        default: begin
          if ($urandom_range(4) == 0)
            repeat ($urandom_range(3, 1)) stamp.push_back(any_char());
        end
      endcase
    end
    return mode;
  endfunction

  // Hand over one character word, after an optional idle burst
  task automatic send_char(logic [7:0] c, logic fin, logic tonly);
    if (push_gap_pct != 0 && $urandom_range(99) < push_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    push      <= 1'b1;
    char_code <= c;
    char_last <= fin;
    time_only <= tonly;
    do @(posedge clk); while (full);
    chars_sent++;
  endtask

  // Send the built string; the mode only matters on its first character
  task automatic send_stamp(logic mode);
    for (int i = 0; i < stamp.size(); i++)
      send_char(stamp[i], i == stamp.size() - 1,
                (i == 0) ? mode : 1'($urandom_range(1)));
  endtask

  task automatic run_text(string s, logic mode);
    stamp = text(s);
    send_stamp(mode);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned roll;
    int unsigned keep;
    logic        mode;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings: extremes, every depth, every status and the quiet tails
    push_gap_pct = 10;
    pop_gap_pct <= 10;
    run_text("9999-99-99T99:99:99.999+99:99", 1'b0);
    run_text("0000-00-00T00:00:00.0-00:00", 1'b0);
    run_text("2024", 1'b0);
    run_text("2024-06", 1'b0);
    run_text("2024-06-15", 1'b0);
    run_text("2024-06-15X!!", 1'b0);
    run_text("2024T10", 1'b0);
    run_text("2024-06-15T", 1'b0);
    run_text("12:30:45Zabc", 1'b1);
    run_text("12:30:45.", 1'b1);
    run_text("12:30:45.99999999", 1'b1);
    run_text("12:30:45.1Z", 1'b1);
    run_text("12:30:45.12a", 1'b1);
    run_text("2024/06", 1'b0);
    run_text("20/4", 1'b0);
    run_text("20:4", 1'b0);
    run_text("2024-0", 1'b0);
    run_text("12+05", 1'b1);
    run_text("12:30+05:3", 1'b1);
    run_text("12:30+05:30junk", 1'b1);
    run_text("12:30-05x", 1'b1);
    run_text("12:3", 1'b1);
    run_text("T", 1'b0);
    stamp = text("2024-");
    stamp.push_back(8'hFF);
    send_stamp(1'b0);
    stamp = text("12:30:45");
    stamp.push_back(8'h00);
    stamp.push_back(8'hFF);
    send_stamp(1'b1);

    // Random strings: mostly well formed, the rest cut, corrupted or noise
    random_start = chars_sent;
    while (chars_sent < random_start + 1350) begin
      if (chars_sent > random_start + 1150) begin
        push_gap_pct = 0;
        pop_gap_pct <= 0;
      end else if ($urandom_range(15) == 0) begin
        push_gap_pct = pick_gap();
        pop_gap_pct <= pick_gap();
      end
      roll = $urandom_range(99);
      mode = build_stamp();
      if (roll >= 92) begin
        stamp.delete();
        repeat ($urandom_range(10, 1)) stamp.push_back(any_char());
      end else if (roll >= 82) begin
        stamp[$urandom_range(stamp.size() - 1)] = any_char();
      end else if (roll >= 70) begin
        keep = $urandom_range(stamp.size(), 1);
        while (stamp.size() > keep) void'(stamp.pop_back());
      end
      send_stamp(mode);
    end
    push <= 1'b0;

    // Drain the pop side, then allow for the block's latency
    @(posedge clk);
    while (stamps_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && stamps_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
